// File: rtl/brb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the byte ring buffer.
// No dependencies; every other file refers to this package by scoped names.
package brb_pkg;

  localparam int unsigned LANES  = 8;
  localparam int unsigned LANE_W = 3;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = LANES * BYTE_W;
  localparam int unsigned RUN_W  = 4;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned LEN_W  = 13;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_ADV_WR = 3'd3,
    OP_ADV_RD = 3'd4,
    OP_CLR    = 3'd5
  } brb_op_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [RUN_W-1:0] wr_len;
  } brb_lane_cmd_t;

endpackage

// File: rtl/brb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for operation beats and result beats.
// Depends on brb_pkg for field widths.
interface brb_in_if;
  logic                         valid;
  logic                         ready;
  logic [brb_pkg::OP_W-1:0]     opcode;
  logic [brb_pkg::LEN_W-1:0]    length;
  logic [brb_pkg::WORD_W-1:0]   data_in;

  modport source (output valid, output opcode, output length, output data_in, input ready);
  modport sink   (input valid, input opcode, input length, input data_in, output ready);
endinterface

interface brb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic [brb_pkg::WORD_W-1:0]   data_out;
  logic [brb_pkg::LEN_W-1:0]    used_bytes;
  logic [brb_pkg::LEN_W-1:0]    free_bytes;
  logic [brb_pkg::LEN_W-1:0]    direct_enqueue_span;
  logic [brb_pkg::LEN_W-1:0]    direct_dequeue_span;

  modport source (output valid, output accepted, output data_out, output used_bytes,
                  output free_bytes, output direct_enqueue_span,
                  output direct_dequeue_span, input ready);
  modport sink   (input valid, input accepted, input data_out, input used_bytes,
                  input free_bytes, input direct_enqueue_span,
                  input direct_dequeue_span, output ready);
endinterface

// File: rtl/brb_lane.sv
`timescale 1ns / 1ps
// One byte bank of the ring store: holds every address whose low three bits equal LANE.
// Depends on brb_pkg for the lane command struct and lane constants.
module brb_lane #(
  parameter int unsigned LANE     = 0,
  parameter int unsigned CAPACITY = 4096
) (
  input  logic                              clk,
  input  brb_pkg::brb_lane_cmd_t            cmd,
  input  logic [$clog2(CAPACITY)-1:0]       wr_ptr,
  input  logic [$clog2(CAPACITY)-1:0]       rd_ptr,
  input  logic [brb_pkg::WORD_W-1:0]        wr_word,
  output logic [brb_pkg::BYTE_W-1:0]        rd_byte_r
);

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned ROWS  = CAPACITY / brb_pkg::LANES;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [brb_pkg::LANE_W-1:0] LANE_IDX = brb_pkg::LANE_W'(LANE);

  function automatic logic [ROW_W-1:0] row_of(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] shifted;
    logic [ROW_W-1:0] base;
    shifted = ptr >> brb_pkg::LANE_W;
    base    = shifted[ROW_W-1:0];
    if (LANE_IDX < ptr[brb_pkg::LANE_W-1:0]) begin
      if (base == ROW_W'(ROWS - 1)) begin
        base = '0;
      end else begin
        base = base + ROW_W'(1);
      end
    end
    return base;
  endfunction

  logic [brb_pkg::BYTE_W-1:0] mem [ROWS];
  logic [brb_pkg::LANE_W-1:0] wr_idx;
  logic                       wr_hit;
  logic [brb_pkg::BYTE_W-1:0] wr_byte;
  logic [ROW_W-1:0]           wr_row;
  logic [ROW_W-1:0]           rd_row;

  assign wr_idx  = LANE_IDX - wr_ptr[brb_pkg::LANE_W-1:0];
  assign wr_hit  = cmd.wr_en && ({1'b0, wr_idx} < cmd.wr_len);
  assign wr_byte = wr_word[{wr_idx, 3'b000} +: brb_pkg::BYTE_W];
  assign wr_row  = row_of(wr_ptr);
  assign rd_row  = row_of(rd_ptr);

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_row] <= wr_byte;
    end
    if (cmd.rd_en) begin
      rd_byte_r <= mem[rd_row];
    end
  end

endmodule

// File: rtl/brb_merge.sv
`timescale 1ns / 1ps
// Merge stage: rotate the bank read bytes into stream order and zero bytes past the run.
// Depends on brb_pkg for lane and word constants.
module brb_merge (
  input  logic [brb_pkg::WORD_W-1:0]  lane_bytes,
  input  logic [brb_pkg::LANE_W-1:0]  rot,
  input  logic [brb_pkg::RUN_W-1:0]   run_len,
  output logic [brb_pkg::WORD_W-1:0]  word
);

  logic [brb_pkg::LANE_W-1:0] sel [brb_pkg::LANES];

  always_comb begin
    for (int i = 0; i < brb_pkg::LANES; i++) begin
      sel[i] = rot + brb_pkg::LANE_W'(i);
      if (brb_pkg::RUN_W'(i) < run_len) begin
        word[i*brb_pkg::BYTE_W +: brb_pkg::BYTE_W] =
          lane_bytes[{sel[i], 3'b000} +: brb_pkg::BYTE_W];
      end else begin
        word[i*brb_pkg::BYTE_W +: brb_pkg::BYTE_W] = '0;
      end
    end
  end

endmodule

// File: rtl/byte_ring_buffer.sv
`timescale 1ns / 1ps
// Byte ring buffer of CAPACITY bytes (a multiple of eight) spread over eight byte banks, so a
// run of up to eight bytes is written or read in one access at any alignment. The accept edge
// commits pointers and bank writes and launches the bank reads; the next edge merges the read
// bytes into the output register unless a result beat held there stalls it. A new beat is
// taken on the edge that moves its predecessor into the output register, giving one beat
// per cycle while the receiver keeps ready high; a result beat held by the receiver holds
// the input. The banks need no clearing pass; bytes never written read as unspecified.
// Depends on brb_pkg, brb_if, brb_lane and brb_merge.
module byte_ring_buffer #(
  parameter int unsigned CAPACITY      = 4096,
  parameter int unsigned MAX_RUN_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  brb_in_if.sink            in_ch,
  brb_out_if.source         out_ch
);

  localparam int unsigned PTR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned LW    = brb_pkg::LEN_W;
  localparam int unsigned CMP_W = (LW > CNT_W) ? LW : CNT_W;
  localparam int unsigned SUM_W = CNT_W + 1;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[PTR_W-1:0];
  endfunction

  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r;
  logic             s_ok_r;
  logic [brb_pkg::RUN_W-1:0]  s_len_r;
  logic [brb_pkg::LANE_W-1:0] s_rot_r;
  logic             out_valid_r;
  logic             accepted_r;
  logic [brb_pkg::WORD_W-1:0] data_out_r;
  logic [LW-1:0]    used_r, free_r, enq_span_r, deq_span_r;

  brb_pkg::brb_op_t          op;
  logic [CMP_W-1:0]          len_x, cnt_x, free_x, max_x;
  logic [CNT_W-1:0]          len_c;
  logic                      too_long, ok, in_acc, drain;
  logic [brb_pkg::RUN_W-1:0] rd_len;
  brb_pkg::brb_lane_cmd_t    lane_cmd;
  logic [brb_pkg::WORD_W-1:0] lane_bytes;
  logic [brb_pkg::WORD_W-1:0] merged;
  logic [CNT_W-1:0]          free_c, enq_c, deq_c;

  assign drain       = busy_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !busy_r || drain;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    op       = brb_pkg::brb_op_t'(in_ch.opcode);
    len_x    = CMP_W'(in_ch.length);
    cnt_x    = CMP_W'(cnt_r);
    free_x   = CMP_W'(CAPACITY) - cnt_x;
    max_x    = CMP_W'(MAX_RUN_BYTES);
    len_c    = CNT_W'(in_ch.length);
    too_long = (op inside {brb_pkg::OP_ENQ, brb_pkg::OP_DEQ, brb_pkg::OP_PEEK})
               && (len_x > max_x);
    case (op)
      brb_pkg::OP_ENQ, brb_pkg::OP_ADV_WR: begin
        ok = !too_long && (len_x <= free_x);
      end
      brb_pkg::OP_DEQ, brb_pkg::OP_PEEK, brb_pkg::OP_ADV_RD: begin
        ok = !too_long && (len_x <= cnt_x);
      end
      brb_pkg::OP_CLR: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    rp_nxt  = rp_r;
    wp_nxt  = wp_r;
    cnt_nxt = cnt_r;
    if (in_acc && ok) begin
      case (op)
        brb_pkg::OP_ENQ, brb_pkg::OP_ADV_WR: begin
          wp_nxt  = wrap_add(wp_r, len_c);
          cnt_nxt = cnt_r + len_c;
        end
        brb_pkg::OP_DEQ, brb_pkg::OP_ADV_RD: begin
          rp_nxt  = wrap_add(rp_r, len_c);
          cnt_nxt = cnt_r - len_c;
        end
        brb_pkg::OP_CLR: begin
          rp_nxt  = '0;
          wp_nxt  = '0;
          cnt_nxt = '0;
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
    end

    rd_len = (ok && (op inside {brb_pkg::OP_DEQ, brb_pkg::OP_PEEK}))
             ? in_ch.length[brb_pkg::RUN_W-1:0] : '0;

    lane_cmd.wr_en  = in_acc && ok && (op == brb_pkg::OP_ENQ);
    lane_cmd.rd_en  = in_acc;
    lane_cmd.wr_len = in_ch.length[brb_pkg::RUN_W-1:0];
  end

  for (genvar k = 0; k < brb_pkg::LANES; k++) begin : g_lane
    brb_lane #(
      .LANE     (k),
      .CAPACITY (CAPACITY)
    ) u_lane (
      .clk       (clk),
      .cmd       (lane_cmd),
      .wr_ptr    (wp_r),
      .rd_ptr    (rp_r),
      .wr_word   (in_ch.data_in),
      .rd_byte_r (lane_bytes[k*brb_pkg::BYTE_W +: brb_pkg::BYTE_W])
    );
  end

  brb_merge u_merge (
    .lane_bytes (lane_bytes),
    .rot        (s_rot_r),
    .run_len    (s_len_r),
    .word       (merged)
  );

  always_comb begin
    free_c = CNT_W'(CAPACITY) - cnt_r;
    if (free_c == '0) begin
      enq_c = '0;
    end else if (wp_r < rp_r) begin
      enq_c = CNT_W'(rp_r) - CNT_W'(wp_r);
    end else begin
      enq_c = CNT_W'(CAPACITY) - CNT_W'(wp_r);
    end
    if (cnt_r == '0) begin
      deq_c = '0;
    end else if (rp_r < wp_r) begin
      deq_c = CNT_W'(wp_r) - CNT_W'(rp_r);
    end else begin
      deq_c = CNT_W'(CAPACITY) - CNT_W'(rp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r        <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rp_r  <= rp_nxt;
      wp_r  <= wp_nxt;
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (drain) begin
        busy_r <= 1'b0;
      end
      if (drain) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_ok_r  <= ok;
      s_len_r <= rd_len;
      s_rot_r <= rp_r[brb_pkg::LANE_W-1:0];
    end
    if (drain) begin
      accepted_r <= s_ok_r;
      data_out_r <= merged;
      used_r     <= LW'(cnt_r);
      free_r     <= LW'(free_c);
      enq_span_r <= LW'(enq_c);
      deq_span_r <= LW'(deq_c);
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.accepted            = accepted_r;
  assign out_ch.data_out            = data_out_r;
  assign out_ch.used_bytes          = used_r;
  assign out_ch.free_bytes          = free_r;
  assign out_ch.direct_enqueue_span = enq_span_r;
  assign out_ch.direct_dequeue_span = deq_span_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_add(rp_r, cnt_r) == wp_r)
    else $error("write pointer out of step with read pointer and fill count");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !accepted_r |-> data_out_r == '0)
    else $error("rejected beat carries data");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("accepted beat lost before merge");

endmodule
